[hdl/ftcs_pkg.sv]
// shared constants, types and codes for the ftcs diffusion stencil
package ftcs_pkg;

   localparam int SAMPLE_BITS     = 32;
   localparam int RATIO_FRAC_BITS = 16;
   localparam int STEP_BITS       = 32;
   localparam int TIME_BITS       = 48;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int SEEN_BITS       = 2;
   localparam int COUNT_BITS      = 2;
   localparam int SLOTS           = 3;

   // c[i+1] + c[i-1] - 2c[i] needs two extra bits; DIFF_BITS gives three
   localparam int DIFF_BITS  = SAMPLE_BITS + 3;
   localparam int PROD_BITS  = DIFF_BITS + RATIO_FRAC_BITS + 1;
   localparam int DELTA_BITS = PROD_BITS - RATIO_FRAC_BITS;
   localparam int SUM_BITS   = DELTA_BITS + 1;

   localparam logic [RATIO_FRAC_BITS-1:0] RATIO_HALF =
      RATIO_FRAC_BITS'(1) << (RATIO_FRAC_BITS - 1);

   localparam logic [SEEN_BITS-1:0] SEEN_NONE = SEEN_BITS'(0);
   localparam logic [SEEN_BITS-1:0] SEEN_ONE  = SEEN_BITS'(1);
   localparam logic [SEEN_BITS-1:0] SEEN_TWO  = SEEN_BITS'(2);
   localparam logic [SEEN_BITS-1:0] SEEN_MANY = SEEN_BITS'(3);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [RATIO_FRAC_BITS-1:0]    ratio_type;
   typedef logic [STEP_BITS-1:0]          step_type;
   typedef logic [TIME_BITS-1:0]          time_type;
   typedef logic [CSR_DATA_BITS-1:0]      csr_data_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIX_RATIO = 1'b0,
      CSR_TIME_STEP = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_STEPPED  = 2'd0,
      ST_UNSTABLE = 2'd1,
      ST_SHORT    = 2'd2
   } status_type;

   // one accepted item together with the window as it stood before it
   typedef struct packed {
      sample_type           sample;
      logic                 is_final;
      sample_type           older;
      sample_type           newer;
      logic [SEEN_BITS-1:0] seen;
   } win_item_type;

   // every result that one item causes
   typedef struct packed {
      sample_type [SLOTS-1:0] vals;
      logic [COUNT_BITS-1:0]  count;
      logic                   is_final;
      status_type             status;
      logic                   stepped;
   } bundle_type;

endpackage

[hdl/ftcs_diffusion_stencil_step_top.sv]
// top level of the ftcs diffusion stencil: config, elapsed time, result queue
// path: an accepted item waits in the window's input register, its results in the result queue
// throughput: one item per cycle while each item causes at most one result and rsp_stall
//   is low; an item causing more results holds the next one until its last result leaves the single result port
// reset: synchronous, clears registers, window, point count, elapsed time and queue
module ftcs_diffusion_stencil_step_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ftcs_pkg::sample_type   req_sample,
   input  logic                   req_is_final,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ftcs_pkg::sample_type   rsp_value,
   output logic                   rsp_final_out,
   output logic [1:0]             rsp_status,
   output ftcs_pkg::time_type     rsp_elapsed_time,
   input  logic                   csr_write,
   input  ftcs_pkg::csr_index_type csr_index,
   input  ftcs_pkg::csr_data_type csr_wdata
);
   import ftcs_pkg::*;

   // config registers
   ratio_type mix_ratio_ff;
   step_type  time_step_ff;

   // elapsed time across completed steps
   time_type  elapsed_ff, elapsed_in;

   // result queue: the results of one item, oldest in slot zero
   sample_type [SLOTS-1:0] vals_ff, vals_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   fin_ff, fin_in;
   status_type             status_ff, status_in;
   time_type               stamp_ff, stamp_in;

   logic         item_valid;
   win_item_type item;
   bundle_type   bundle;
   logic         rsp_taken;
   logic         load_ok;
   logic         item_take;

   ftcs_window u_window (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .req_is_final (req_is_final),
      .item_valid   (item_valid),
      .item         (item),
      .item_take    (item_take)
   );

   ftcs_stencil u_stencil (
      .item      (item),
      .mix_ratio (mix_ratio_ff),
      .bundle    (bundle)
   );

   // the queue takes a new item once its last result leaves
   assign rsp_taken = (count_ff != '0) && !rsp_stall;
   assign load_ok   = (count_ff == '0) ||
                      (count_ff == COUNT_BITS'(1) && rsp_taken);
   assign item_take = item_valid && load_ok;

   always_comb begin
      elapsed_in = elapsed_ff;
      vals_in    = vals_ff;
      count_in   = count_ff;
      fin_in     = fin_ff;
      status_in  = status_ff;
      stamp_in   = stamp_ff;
      if (item_take) begin
         // a completed step advances time before its results go out
         if (bundle.stepped) begin
            elapsed_in = elapsed_ff + TIME_BITS'(time_step_ff);
         end
         vals_in   = bundle.vals;
         count_in  = bundle.count;
         fin_in    = bundle.is_final;
         status_in = bundle.status;
         stamp_in  = bundle.stepped ? elapsed_ff + TIME_BITS'(time_step_ff)
                                    : elapsed_ff;
      end else if (rsp_taken) begin
         vals_in[0] = vals_ff[1];
         vals_in[1] = vals_ff[2];
         count_in   = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ratio_ff <= '0;
         time_step_ff <= '0;
         elapsed_ff   <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_MIX_RATIO: mix_ratio_ff <= csr_wdata[RATIO_FRAC_BITS-1:0];
               CSR_TIME_STEP: time_step_ff <= csr_wdata[STEP_BITS-1:0];
               default: ;
            endcase
         end
         elapsed_ff <= elapsed_in;
         count_ff   <= count_in;
      end
      vals_ff   <= vals_in;
      fin_ff    <= fin_in;
      status_ff <= status_in;
      stamp_ff  <= stamp_in;
   end

   assign rsp_valid        = count_ff != '0;
   assign rsp_value        = vals_ff[0];
   // the profile's last point is the last result of its item
   assign rsp_final_out    = fin_ff && (count_ff == COUNT_BITS'(1));
   assign rsp_status       = status_ff;
   assign rsp_elapsed_time = stamp_ff;

endmodule

[hdl/ftcs_window.sv]
// input register and two-sample window with point count
module ftcs_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ftcs_pkg::sample_type  req_sample,
   input  logic                  req_is_final,
   output logic                  item_valid,
   output ftcs_pkg::win_item_type item,
   input  logic                  item_take
);
   import ftcs_pkg::*;

   logic                 item_valid_ff, item_valid_in;
   win_item_type         item_ff, item_in;
   sample_type           older_ff, older_in;
   sample_type           newer_ff, newer_in;
   logic [SEEN_BITS-1:0] seen_ff, seen_in;
   logic                 accept;

   assign req_stall  = item_valid_ff && !item_take;
   assign accept     = req_valid && !req_stall;
   assign item_valid = item_valid_ff;
   assign item       = item_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      older_in      = older_ff;
      newer_in      = newer_ff;
      seen_in       = seen_ff;
      if (item_take) begin
         item_valid_in = 1'b0;
      end
      if (accept) begin
         item_valid_in    = 1'b1;
         item_in.sample   = req_sample;
         item_in.is_final = req_is_final;
         item_in.older    = older_ff;
         item_in.newer    = newer_ff;
         item_in.seen     = seen_ff;
         if (req_is_final) begin
            older_in = '0;
            newer_in = '0;
            seen_in  = SEEN_NONE;
         end else begin
            older_in = newer_ff;
            newer_in = req_sample;
            seen_in  = (seen_ff == SEEN_MANY) ? SEEN_MANY : seen_ff + SEEN_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         older_ff      <= '0;
         newer_ff      <= '0;
         seen_ff       <= SEEN_NONE;
      end else begin
         item_valid_ff <= item_valid_in;
         older_ff      <= older_in;
         newer_ff      <= newer_in;
         seen_ff       <= seen_in;
      end
      item_ff <= item_in;
   end

endmodule

[hdl/ftcs_stencil.sv]
// stencil arithmetic and result set for one item
module ftcs_stencil (
   input  ftcs_pkg::win_item_type item,
   input  ftcs_pkg::ratio_type    mix_ratio,
   output ftcs_pkg::bundle_type   bundle
);
   import ftcs_pkg::*;

   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [PROD_BITS-1:0]  prod;
   logic signed [DELTA_BITS-1:0] delta;
   logic signed [SUM_BITS-1:0]   sum;
   logic [SUM_BITS-SAMPLE_BITS:0] sum_top;
   sample_type                   stepped_val;
   sample_type                   mid_val;
   sample_type                   first_val;
   sample_type                   last_val;
   logic                         unstable;
   logic                         short_pass;

   always_comb begin
      diff = DIFF_BITS'(item.older) + DIFF_BITS'(item.sample)
           - (DIFF_BITS'(item.newer) <<< 1);
      prod  = PROD_BITS'(diff) * $signed({1'b0, mix_ratio});
      // arithmetic shift floors toward minus infinity
      delta = DELTA_BITS'(prod >>> RATIO_FRAC_BITS);
      sum   = SUM_BITS'(item.newer) + SUM_BITS'(delta);
      sum_top = sum[SUM_BITS-1:SAMPLE_BITS-1];
      if (sum_top == '0 || sum_top == '1) begin
         stepped_val = sum[SAMPLE_BITS-1:0];
      end else if (sum[SUM_BITS-1]) begin
         stepped_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         stepped_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end

      unstable   = mix_ratio > RATIO_HALF;
      short_pass = (item.seen == SEEN_NONE) || (item.seen == SEEN_ONE);
      mid_val    = unstable ? item.newer : stepped_val;
      first_val  = unstable ? item.older : mid_val;
      last_val   = unstable ? item.sample : mid_val;

      bundle.is_final = item.is_final;
      bundle.vals[2]  = last_val;
      if (short_pass) begin
         // too short only shows once the last point arrives
         bundle.vals[0] = (item.seen == SEEN_ONE) ? item.newer : item.sample;
         bundle.vals[1] = item.sample;
         bundle.status  = ST_SHORT;
         bundle.stepped = 1'b0;
         if (!item.is_final) begin
            bundle.count = COUNT_BITS'(0);
         end else if (item.seen == SEEN_ONE) begin
            bundle.count = COUNT_BITS'(2);
         end else begin
            bundle.count = COUNT_BITS'(1);
         end
      end else begin
         bundle.vals[0] = (item.seen == SEEN_TWO) ? first_val : mid_val;
         bundle.vals[1] = (item.seen == SEEN_TWO) ? mid_val : last_val;
         bundle.status  = unstable ? ST_UNSTABLE : ST_STEPPED;
         bundle.stepped = item.is_final && !unstable;
         bundle.count   = COUNT_BITS'(1)
                        + COUNT_BITS'(item.seen == SEEN_TWO)
                        + COUNT_BITS'(item.is_final);
      end
   end

endmodule
